[hdl/blac_pkg.sv]
// ----------------------------------------------------------------------------
// blac_pkg
// Shared types, codes and helpers of the binned lookup additive classifier.
// ----------------------------------------------------------------------------
package blac_pkg;

  localparam int unsigned DEF_MAX_FEATURES = 64;
  localparam int unsigned DEF_MAX_CLASSES  = 8;
  localparam int unsigned DEF_MAX_CELLS    = 32;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SCALE_W = 31;
  localparam int unsigned SUM_W   = 40;

  typedef enum logic [1:0] {
    MODE_LOAD_CELL  = 2'd0,
    MODE_LOAD_RANGE = 2'd1,
    MODE_LOAD_PRIOR = 2'd2,
    MODE_CLASSIFY   = 2'd3
  } mode_t;

  typedef enum logic {
    REG_CLASSES_IN_USE = 1'b0,
    REG_CELLS_IN_USE   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] minimum;
    logic        [SCALE_W-1:0] scale;
  } range_entry_t;

  // Width of an index into n entries, never below one bit.
  function automatic int unsigned idx_width(input int unsigned n);
    return (n <= 1) ? 1 : $clog2(n);
  endfunction

  // Reduces a six-bit index modulo n by restoring compare and subtract.
  function automatic logic [5:0] wrap_idx(input logic [5:0] v, input int unsigned n);
    logic [16:0] r;
    r = {11'd0, v};
    for (int i = 5; i >= 0; i--) begin
      if (r >= 17'(n << i)) begin
        r = r - 17'(n << i);
      end
    end
    return r[5:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sext_value(input logic [VALUE_W-1:0] x);
    return {{(SUM_W-VALUE_W){x[VALUE_W-1]}}, x};
  endfunction

endpackage

[hdl/blac_binner.sv]
// ----------------------------------------------------------------------------
// blac_binner
// Free-running bin pipeline: subtract the range minimum, scale, then clamp.
// ----------------------------------------------------------------------------
module blac_binner #(
  parameter int unsigned MAX_CELLS = blac_pkg::DEF_MAX_CELLS
) (
  input  logic                                     clk,
  input  logic signed [blac_pkg::VALUE_W-1:0]      value,
  input  blac_pkg::range_entry_t                   range_entry,
  input  logic [blac_pkg::idx_width(MAX_CELLS+1)-1:0] cells_in_use,
  output logic [blac_pkg::idx_width(MAX_CELLS)-1:0]   bin
);
  import blac_pkg::*;

  localparam int unsigned NCELL_W = idx_width(MAX_CELLS + 1);
  localparam int unsigned BIN_W   = idx_width(MAX_CELLS);

  logic signed [VALUE_W:0]   diff_r;
  logic        [SCALE_W-1:0] scale_r;
  logic signed [63:0]        prod_r;
  logic        [31:0]        top_bin;
  logic        [31:0]        last_bin;

  // The difference is sign extended and the scale zero extended to the product width before the multiply.
  always_ff @(posedge clk) begin
    diff_r  <= (VALUE_W+1)'(value) - (VALUE_W+1)'(range_entry.minimum);
    scale_r <= range_entry.scale;
    prod_r  <= 64'(diff_r) * 64'($signed({1'b0, scale_r}));
  end

  // The integer part of the product is the bin; negative products land in bin zero.
  assign top_bin  = prod_r[63:32];
  assign last_bin = 32'(cells_in_use - NCELL_W'(1));

  always_comb begin
    if (prod_r[63]) begin
      bin = '0;
    end else if (top_bin >= last_bin) begin
      bin = BIN_W'(last_bin);
    end else begin
      bin = BIN_W'(top_bin);
    end
  end

endmodule

[hdl/binned_lookup_additive_classifier.sv]
// ----------------------------------------------------------------------------
// binned_lookup_additive_classifier
// Per-feature lookup table classifier: bins a feature value, adds the bin's
// cell of every class to running sums and emits one response per class in use.
//
//   channel   dir  handshake               payload
//   in_*      in   in_valid / in_stall     mode, indices, value, width, last
//   out_*     out  out_valid / out_stall   result_class, response, last_class
//   cfg_*     in   cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// A load transaction is taken only while idle. A classify transaction passes
// range memory read, subtract, multiply, cell memory read and accumulate in
// order, with in_stall high throughout. A final feature then moves the responses
// to the output register one class in use at a time. Reset is synchronous;
// it clears the sums, the open-instance flag and out_valid and restores the
// register defaults, not the tables. out_stall holds the responses in place.
// ----------------------------------------------------------------------------
module binned_lookup_additive_classifier #(
  parameter int unsigned MAX_FEATURES = blac_pkg::DEF_MAX_FEATURES,
  parameter int unsigned MAX_CLASSES  = blac_pkg::DEF_MAX_CLASSES,
  parameter int unsigned MAX_CELLS    = blac_pkg::DEF_MAX_CELLS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [5:0]         in_feature_index,
  input  logic [2:0]         in_class_index,
  input  logic [4:0]         in_cell_index,
  input  logic signed [31:0] in_value,
  input  logic [30:0]        in_inverse_width,
  input  logic               in_last_feature,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_result_class,
  output logic signed [39:0] out_response,
  output logic               out_last_class,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [5:0]         cfg_wdata
);
  import blac_pkg::*;

  localparam int unsigned FEAT_W     = idx_width(MAX_FEATURES);
  localparam int unsigned CLS_W      = idx_width(MAX_CLASSES);
  localparam int unsigned BIN_W      = idx_width(MAX_CELLS);
  localparam int unsigned NCLS_W     = idx_width(MAX_CLASSES + 1);
  localparam int unsigned NCELL_W    = idx_width(MAX_CELLS + 1);
  localparam int unsigned CELL_DEPTH = MAX_FEATURES * MAX_CELLS;
  localparam int unsigned ADDR_W     = idx_width(CELL_DEPTH);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIFF = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_BIN  = 6'b001000,
    ST_ACC  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Each memory word holds the cells of every class for one feature and bin.
  logic [MAX_CLASSES-1:0][VALUE_W-1:0] cell_mem [CELL_DEPTH];
  logic [MAX_CLASSES-1:0][VALUE_W-1:0] cell_rd_r;
  range_entry_t                        range_mem [MAX_FEATURES];
  range_entry_t                        range_rd_r;

  logic        [VALUE_W-1:0] prior_r [MAX_CLASSES];
  logic signed [SUM_W-1:0]   sums_r  [MAX_CLASSES];

  logic               open_r;
  logic [FEAT_W-1:0]  feat_r;
  logic signed [31:0] value_r;
  logic               last_r;
  logic [3:0]         cls_raw_r;
  logic [5:0]         cell_raw_r;
  logic [NCLS_W-1:0]  emit_cnt_r;
  logic               out_valid_r;
  logic [2:0]         out_class_r;
  logic signed [39:0] out_resp_r;
  logic               out_last_r;

  mode_t              mode;
  logic               in_fire;
  logic [FEAT_W-1:0]  f_wrap;
  logic [CLS_W-1:0]   c_wrap;
  logic [BIN_W-1:0]   b_wrap;
  logic [NCLS_W-1:0]  ncls;
  logic [NCELL_W-1:0] ncells;
  logic [BIN_W-1:0]   bin;
  logic [ADDR_W-1:0]  cell_wa;
  logic [ADDR_W-1:0]  cell_ra;
  logic               out_load;
  logic               emit_last;

  assign mode     = mode_t'(in_mode);
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign f_wrap   = FEAT_W'(wrap_idx(in_feature_index, MAX_FEATURES));
  assign c_wrap   = CLS_W'(wrap_idx(6'(in_class_index), MAX_CLASSES));
  assign b_wrap   = BIN_W'(wrap_idx(6'(in_cell_index), MAX_CELLS));

  // Register values outside the supported range saturate.
  always_comb begin
    if (cls_raw_r == 4'd0) begin
      ncls = NCLS_W'(1);
    end else if (32'(cls_raw_r) > MAX_CLASSES) begin
      ncls = NCLS_W'(MAX_CLASSES);
    end else begin
      ncls = NCLS_W'(cls_raw_r);
    end
    if (cell_raw_r == 6'd0) begin
      ncells = NCELL_W'(1);
    end else if (32'(cell_raw_r) > MAX_CELLS) begin
      ncells = NCELL_W'(MAX_CELLS);
    end else begin
      ncells = NCELL_W'(cell_raw_r);
    end
  end

  blac_binner #(
    .MAX_CELLS(MAX_CELLS)
  ) u_binner (
    .clk         (clk),
    .value       (value_r),
    .range_entry (range_rd_r),
    .cells_in_use(ncells),
    .bin         (bin)
  );

  assign cell_wa = ADDR_W'(f_wrap) * ADDR_W'(MAX_CELLS) + ADDR_W'(b_wrap);
  assign cell_ra = ADDR_W'(feat_r) * ADDR_W'(MAX_CELLS) + ADDR_W'(bin);

  always_ff @(posedge clk) begin
    if (in_fire && mode == MODE_LOAD_CELL) begin
      cell_mem[cell_wa][c_wrap] <= in_value;
    end
    if (state_r == ST_BIN) begin
      cell_rd_r <= cell_mem[cell_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && mode == MODE_LOAD_RANGE) begin
      range_mem[f_wrap] <= '{minimum: in_value, scale: in_inverse_width};
    end
    if (in_fire && mode == MODE_CLASSIFY) begin
      range_rd_r <= range_mem[f_wrap];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && mode == MODE_LOAD_PRIOR) begin
      prior_r[c_wrap] <= in_value;
    end
    if (in_fire && mode == MODE_CLASSIFY) begin
      feat_r  <= f_wrap;
      value_r <= in_value;
      last_r  <= in_last_feature;
    end
  end

  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign emit_last = (emit_cnt_r == ncls - NCLS_W'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && mode == MODE_CLASSIFY) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_BIN;
      ST_BIN:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_load && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      open_r      <= 1'b0;
      cls_raw_r   <= 4'd8;
      cell_raw_r  <= 6'd32;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (reg_index_t'(cfg_index))
          REG_CLASSES_IN_USE: cls_raw_r  <= cfg_wdata[3:0];
          REG_CELLS_IN_USE:   cell_raw_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == ST_ACC) begin
        open_r     <= !last_r;
        emit_cnt_r <= '0;
      end else if (out_load) begin
        emit_cnt_r <= emit_cnt_r + NCLS_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Responses leave from lane zero while the sums shift down one lane per result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
        sums_r[i] <= '0;
      end
    end else if (state_r == ST_ACC) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
        sums_r[i] <= (open_r ? sums_r[i] : sext_value(prior_r[i])) + sext_value(cell_rd_r[i]);
      end
    end else if (out_load) begin
      for (int i = 0; i < MAX_CLASSES - 1; i++) begin
        sums_r[i] <= sums_r[i+1];
      end
      sums_r[MAX_CLASSES-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_class_r <= 3'(emit_cnt_r);
      out_resp_r  <= sums_r[0];
      out_last_r  <= emit_last;
    end
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_result_class = out_class_r;
  assign out_response     = out_resp_r;
  assign out_last_class   = out_last_r;

`ifndef SYNTHESIS
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("response appeared outside the emit phase");

  a_classify_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode == MODE_CLASSIFY) |=> (state_r == ST_DIFF))
    else $error("classify transaction did not start the bin pipeline");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (emit_cnt_r < ncls))
    else $error("emit counter ran past the classes in use");

  a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && emit_last) |=> (state_r == ST_IDLE) && out_last_r)
    else $error("final response did not close the instance");
`endif

endmodule

[tb/binned_lookup_additive_classifier_tb.sv]
// ----------------------------------------------------------------------------
// binned_lookup_additive_classifier_tb
// Self-checking testbench of the binned lookup additive classifier. Load and
// classify transactions go through the input channel in random bursts. A
// predictor keeps its own tables, sums and registers and queues the class
// responses that each transaction causes. A checker compares every response
// with the oldest one queued, field by field. The receiver stalls at random,
// on a periodic pattern or for one long hold-off.
// ----------------------------------------------------------------------------
module binned_lookup_additive_classifier_tb;
  import blac_pkg::*;

  localparam int unsigned FEATURES      = DEF_MAX_FEATURES;
  localparam int unsigned CLASSES       = DEF_MAX_CLASSES;
  localparam int unsigned CELLS         = DEF_MAX_CELLS;
  localparam int unsigned CELL_DEPTH    = FEATURES * CLASSES * CELLS;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 300;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  typedef struct {
    mode_t              mode;
    logic [5:0]         feature;
    logic [2:0]         cls;
    logic [4:0]         bin_index;
    logic signed [31:0] value;
    logic [30:0]        scale;
    logic               last;
  } feature_item_t;

  typedef struct {
    logic [2:0]         cls;
    logic signed [39:0] response;
    logic               last;
  } class_response_t;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic [1:0]         in_mode          = '0;
  logic [5:0]         in_feature_index = '0;
  logic [2:0]         in_class_index   = '0;
  logic [4:0]         in_cell_index    = '0;
  logic signed [31:0] in_value         = '0;
  logic [30:0]        in_inverse_width = '0;
  logic               in_last_feature  = 1'b0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic [2:0]         out_result_class;
  logic signed [39:0] out_response;
  logic               out_last_class;
  logic               cfg_valid        = 1'b0;
  logic               cfg_ready;
  logic               cfg_index        = 1'b0;
  logic [5:0]         cfg_wdata        = '0;

  // Predictor state.
  logic [31:0]        cell_mem     [CELL_DEPTH];
  bit                 cell_loaded  [CELL_DEPTH];
  logic signed [31:0] range_min    [FEATURES];
  logic [30:0]        range_scale  [FEATURES];
  bit                 range_loaded [FEATURES];
  logic [31:0]        prior_mem    [CLASSES];
  bit                 prior_loaded [CLASSES];
  logic signed [39:0] class_sum    [CLASSES];
  bit                 instance_open = 1'b0;
  logic [3:0]         classes_reg   = 4'd8;
  logic [5:0]         cells_reg     = 6'd32;
  class_response_t    response_q [$];

  // Traffic control.
  int unsigned  items_sent    = 0;
  int unsigned  burst_left    = 0;
  int unsigned  gap_max       = 3;
  stall_style_t stall_style   = STALL_LIGHT;
  int unsigned  hold_request  = 0;
  int unsigned  hold_left     = 0;
  int unsigned  stall_phase   = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count   = 0;
  logic [5:0]   feature_pool [4];

  binned_lookup_additive_classifier i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_feature_index (in_feature_index),
    .in_class_index   (in_class_index),
    .in_cell_index    (in_cell_index),
    .in_value         (in_value),
    .in_inverse_width (in_inverse_width),
    .in_last_feature  (in_last_feature),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_class (out_result_class),
    .out_response     (out_response),
    .out_last_class   (out_last_class),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned classes_active();
    if (classes_reg < 1) return 1;
    if (classes_reg > CLASSES) return CLASSES;
    return classes_reg;
  endfunction

  function automatic int unsigned cells_active();
    if (cells_reg < 1) return 1;
    if (cells_reg > CELLS) return CELLS;
    return cells_reg;
  endfunction

  function automatic int unsigned cell_addr(input logic [5:0] f, input int unsigned k,
                                            input int unsigned b);
    return {f, 3'(k), 5'(b)};
  endfunction

  // The bin is the integer part of (value - minimum) * scale, held to the bins in use.
  function automatic int unsigned feature_bin(input logic [5:0] f,
                                              input logic signed [31:0] v);
    longint      diff;
    longint      prod;
    int unsigned top;
    top  = cells_active() - 1;
    diff = longint'(v) - longint'(range_min[f]);
    prod = diff * longint'({1'b0, range_scale[f]});
    if (prod < 0) return 0;
    if ((prod >>> 32) > longint'(top)) return top;
    return 32'(prod >>> 32);
  endfunction

  function automatic void predict_responses(input feature_item_t it);
    int unsigned     addr;
    int unsigned     bin;
    int unsigned     n;
    class_response_t r;
    case (it.mode)
      MODE_LOAD_CELL: begin
        addr = cell_addr(it.feature, it.cls, it.bin_index);
        cell_mem[addr]    = it.value;
        cell_loaded[addr] = 1'b1;
      end
      MODE_LOAD_RANGE: begin
        range_min[it.feature]    = it.value;
        range_scale[it.feature]  = it.scale;
        range_loaded[it.feature] = 1'b1;
      end
      MODE_LOAD_PRIOR: begin
        prior_mem[it.cls]    = it.value;
        prior_loaded[it.cls] = 1'b1;
      end
      MODE_CLASSIFY: begin
        if (!instance_open) begin
          for (int k = 0; k < CLASSES; k++) begin
            class_sum[k] = {{8{prior_mem[k][31]}}, prior_mem[k]};
          end
          instance_open = 1'b1;
        end
        bin = feature_bin(it.feature, it.value);
        for (int k = 0; k < CLASSES; k++) begin
          addr = cell_addr(it.feature, k, bin);
          class_sum[k] += {{8{cell_mem[addr][31]}}, cell_mem[addr]};
        end
        if (it.last) begin
          n = classes_active();
          for (int k = 0; k < n; k++) begin
            r.cls      = 3'(k);
            r.response = class_sum[k];
            r.last     = (k == n - 1);
            response_q.push_back(r);
          end
          instance_open = 1'b0;
        end
      end
    endcase
  endfunction

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin
    class_response_t e;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (response_q.size() == 0) begin
        $display("%0t: response with none expected, class %0d response %0d",
                 $time, out_result_class, out_response);
        mismatch_count++;
      end else begin
        e = response_q.pop_front();
        if (out_result_class !== e.cls) begin
          $display("%0t: result_class expected %0d actual %0d",
                   $time, e.cls, out_result_class);
          mismatch_count++;
        end
        if (out_response !== e.response) begin
          $display("%0t: response of class %0d expected %0d actual %0d",
                   $time, e.cls, e.response, out_response);
          mismatch_count++;
        end
        if (out_last_class !== e.last) begin
          $display("%0t: last_class of class %0d expected %0b actual %0b",
                   $time, e.cls, e.last, out_last_class);
          mismatch_count++;
        end
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    stall_phase++;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:     out_stall <= ((stall_phase % 6) < 2);
      endcase
    end
  end

  // ------------------------------------------------------------------- sender

  task automatic drive_transaction(input feature_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_mode          <= it.mode;
    in_feature_index <= it.feature;
    in_class_index   <= it.cls;
    in_cell_index    <= it.bin_index;
    in_value         <= it.value;
    in_inverse_width <= it.scale;
    in_last_feature  <= it.last;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    predict_responses(it);
  endtask

  task automatic wait_for_responses();
    while (response_q.size() != 0) @(posedge clk);
  endtask

  // Input lowered, every response in, and time for any load still in flight.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    burst_left = 0;
    wait_for_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [5:0] data);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == REG_CLASSES_IN_USE) classes_reg = data[3:0];
    else cells_reg = data;
  endtask

  // Fields that a mode does not use still carry random bits.
  function automatic feature_item_t random_item(input mode_t m);
    feature_item_t it;
    it.mode      = m;
    it.feature   = 6'($urandom);
    it.cls       = 3'($urandom);
    it.bin_index = 5'($urandom);
    it.value     = $urandom;
    it.scale     = 31'($urandom);
    it.last      = 1'($urandom);
    return it;
  endfunction

  function automatic logic signed [31:0] random_q16();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed(32'($urandom_range(0, 32'h001F_FFFF))) - 32'sh0010_0000;
  endfunction

  task automatic load_cell(input logic [5:0] f, input logic [2:0] c, input logic [4:0] b,
                           input logic signed [31:0] v);
    feature_item_t it;
    it = random_item(MODE_LOAD_CELL);
    it.feature   = f;
    it.cls       = c;
    it.bin_index = b;
    it.value     = v;
    drive_transaction(it);
  endtask

  task automatic load_range(input logic [5:0] f, input logic signed [31:0] minimum,
                            input logic [30:0] scale);
    feature_item_t it;
    it = random_item(MODE_LOAD_RANGE);
    it.feature = f;
    it.value   = minimum;
    it.scale   = scale;
    drive_transaction(it);
  endtask

  task automatic load_prior(input logic [2:0] c, input logic signed [31:0] v);
    feature_item_t it;
    it = random_item(MODE_LOAD_PRIOR);
    it.cls   = c;
    it.value = v;
    drive_transaction(it);
  endtask

  // Loads whatever a lookup of this value would read before it was ever written,
  // then sends the feature value itself.
  task automatic classify_value(input logic [5:0] f, input logic signed [31:0] v,
                                input logic last);
    feature_item_t it;
    int unsigned   bin;
    if (!range_loaded[f]) begin
      load_range(f, $signed(32'($urandom_range(0, 32'h01FF_FFFF))) - 32'sh0100_0000,
                 31'($urandom_range(32'h0000_1000, 32'h0010_0000)));
    end
    if (!instance_open) begin
      for (int k = 0; k < CLASSES; k++) begin
        if (!prior_loaded[k]) load_prior(3'(k), random_q16());
      end
    end
    bin = feature_bin(f, v);
    for (int k = 0; k < CLASSES; k++) begin
      if (!cell_loaded[cell_addr(f, k, bin)]) load_cell(f, 3'(k), 5'(bin), random_q16());
    end
    it = random_item(MODE_CLASSIFY);
    it.feature = f;
    it.value   = v;
    it.last    = last;
    drive_transaction(it);
  endtask

  // Mostly a value aimed at a chosen bin, sometimes below the range or anywhere.
  function automatic logic signed [31:0] pick_value(input logic [5:0] f);
    longint      target;
    longint      off;
    longint      v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom;
    if (r < 25) begin
      v = longint'(range_min[f]) - longint'($urandom_range(1, 1 << 20));
    end else begin
      target = $urandom_range(0, cells_active());
      off = 0;
      if (range_scale[f] != 0) begin
        off = ((target << 32) + longint'($urandom)) / longint'({1'b0, range_scale[f]});
      end
      v = longint'(range_min[f]) + off;
    end
    if (longint'(int'(v)) != v) return $urandom;
    return 32'(v);
  endfunction

  task automatic classify_random(input logic [5:0] f, input logic last);
    logic signed [31:0] v;
    if (!range_loaded[f]) classify_value(f, 32'sd0, 1'b0);
    v = pick_value(f);
    classify_value(f, v, last);
  endtask

  function automatic logic [5:0] pick_feature();
    if ($urandom_range(0, 4) == 0) return 6'($urandom);
    return feature_pool[$urandom_range(0, 3)];
  endfunction

  task automatic random_load();
    case ($urandom_range(0, 2))
      0: load_cell(6'($urandom), 3'($urandom), 5'($urandom), random_q16());
      1: begin
        if ($urandom_range(0, 1) == 0) load_range(pick_feature(), $urandom, 31'($urandom));
        else load_range(pick_feature(), random_q16(),
                        31'($urandom_range(32'h0000_1000, 32'h0010_0000)));
      end
      default: load_prior(3'($urandom), random_q16());
    endcase
  endtask

  task automatic run_traffic(input int unsigned n);
    int unsigned target;
    int unsigned r;
    int unsigned nfeat;
    target = items_sent + n;
    for (int i = 0; i < 4; i++) feature_pool[i] = 6'($urandom);
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        nfeat = $urandom_range(1, 5);
        for (int i = 0; i < nfeat; i++) begin
          if ($urandom_range(0, 9) == 0) random_load();
          classify_random(pick_feature(), i == nfeat - 1);
        end
      end else if (r < 90) begin
        random_load();
      end else begin
        // A feature without the last flag leaves the instance open across steps.
        classify_random(pick_feature(), 1'b0);
      end
    end
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_directed();
    load_prior(3'd0, 32'sh7FFF_FFFF);
    load_prior(3'd1, 32'sh8000_0000);
    load_prior(3'd2, 32'sd0);
    load_prior(3'd3, -32'sd1);
    for (int k = 4; k < CLASSES; k++) load_prior(3'(k), random_q16());
    // Feature 0 has one bin per unit; feature 63 has the widest range and largest scale.
    load_range(6'd0, 32'sd0, 31'h0001_0000);
    load_range(6'd63, 32'sh8000_0000, 31'h7FFF_FFFF);
    load_range(6'd1, random_q16(), 31'd0);
    load_cell(6'd0, 3'd0, 5'd0, 32'sh7FFF_FFFF);
    load_cell(6'd0, 3'd1, 5'd0, 32'sh8000_0000);
    classify_value(6'd0, -32'sd327680, 1'b1);        // below the minimum: bin 0
    classify_value(6'd0, 32'sd196608, 1'b0);         // exactly on the edge of bin 3
    classify_value(6'd0, 32'sd196607, 1'b0);         // just under it: bin 2
    classify_value(6'd63, 32'sh7FFF_FFFF, 1'b0);     // far past the top: last bin
    // A cell loaded while the instance is open is seen by its next lookup.
    load_cell(6'd0, 3'd3, 5'd31, random_q16());
    classify_value(6'd0, 32'sd65536000, 1'b1);
    classify_value(6'd63, 32'sh8000_0000, 1'b1);     // zero distance, one-feature instance
    classify_value(6'd1, random_q16(), 1'b1);        // zero scale always lands in bin 0
  endtask

  task automatic test_register_extremes();
    logic [5:0] classes_set [6] = '{6'd1, 6'd0, 6'd15, 6'h3A, 6'd5, 6'd8};
    logic [5:0] cells_set   [6] = '{6'd1, 6'd0, 6'd63, 6'd2, 6'd17, 6'd32};
    for (int i = 0; i < 6; i++) begin
      write_register(REG_CLASSES_IN_USE, classes_set[i]);
      write_register(REG_CELLS_IN_USE, cells_set[i]);
      stall_style = stall_style_t'($urandom_range(0, 3));
      gap_max     = $urandom_range(0, 5);
      run_traffic(10);
    end
  endtask

  task automatic test_backpressure();
    write_register(REG_CLASSES_IN_USE, 6'd8);
    stall_style  = STALL_NONE;
    gap_max      = 0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 4; i++) feature_pool[i] = 6'($urandom);
    repeat (8) classify_random(pick_feature(), 1'b1);
    // The sender waits here until the last response has been taken.
    in_valid <= 1'b0;
    burst_left = 0;
    wait_for_responses();
    stall_style = STALL_LIGHT;
    gap_max     = 3;
    run_traffic(10);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      write_register(REG_CLASSES_IN_USE, 6'($urandom_range(0, 15)));
      write_register(REG_CELLS_IN_USE, 6'($urandom));
      if (phase == 0) begin
        stall_style = STALL_NONE;
        gap_max     = 0;
      end else begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        gap_max     = $urandom_range(1, 8);
      end
      run_traffic(20);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    wait_quiet();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/blac_pkg.sv
hdl/blac_binner.sv
hdl/binned_lookup_additive_classifier.sv
tb/binned_lookup_additive_classifier_tb.sv
